// ===== src/sxfb_pkg.sv =====
// Shared types and constants for the sprite XOR framebuffer.
// Holds the item structs, the mode codes and the default screen size.
// No dependencies.
`timescale 1ns / 1ps

package sxfb_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 64;
  localparam int unsigned SCREEN_HEIGHT_DEF = 32;

  // Pixels in one sprite row.
  localparam int unsigned SPRITE_W = 8;

  localparam logic [1:0] MODE_DRAW  = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [3:0] row_index;
    logic [7:0] row_bits;
    logic       last_row;
  } sxfb_in_t;

  typedef struct packed {
    logic collision;
    logic pixel_value;
    logic sprite_done;
  } sxfb_out_t;

  // Write side command from the row logic to the frame memory.
  typedef struct packed {
    logic wr_en;
    logic clr;
  } sxfb_mem_cmd_t;

endpackage

// ===== src/sxfb_wrap.sv =====
// Coordinate wrap for the sprite XOR framebuffer.
// Turns the raw x, y and row index into a screen column and a memory row.
// Depends on sxfb_pkg.
`timescale 1ns / 1ps

module sxfb_wrap import sxfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  localparam int unsigned COL_W = $clog2(SCREEN_WIDTH),
  localparam int unsigned ROW_W = $clog2(SCREEN_HEIGHT)
) (
  input  sxfb_in_t         item_i,
  output logic [COL_W-1:0] col_o,
  output logic [ROW_W-1:0] row_o
);

  localparam logic [ROW_W:0] HeightL = (ROW_W+1)'(SCREEN_HEIGHT);

  // Modulo tables, filled with constants at elaboration.
  logic [COL_W-1:0] x_tbl  [256];
  logic [ROW_W-1:0] y_tbl  [256];
  logic [ROW_W-1:0] ri_tbl [16];

  logic [ROW_W-1:0] y_base;
  logic [ROW_W:0]   y_sum;
  logic [ROW_W-1:0] y_draw;

  for (genvar gi = 0; gi < 256; gi++) begin : g_xy_tbl
    assign x_tbl[gi] = COL_W'(gi % SCREEN_WIDTH);
    assign y_tbl[gi] = ROW_W'(gi % SCREEN_HEIGHT);
  end

  for (genvar gr = 0; gr < 16; gr++) begin : g_ri_tbl
    assign ri_tbl[gr] = ROW_W'(gr % SCREEN_HEIGHT);
  end

  // Both terms are below the height, so one subtract finishes the wrap.
  assign y_base = y_tbl[item_i.y_pos];
  assign y_sum  = {1'b0, y_base} + {1'b0, ri_tbl[item_i.row_index]};

  always_comb begin
    if (y_sum >= HeightL) begin
      y_draw = ROW_W'(y_sum - HeightL);
    end else begin
      y_draw = y_sum[ROW_W-1:0];
    end
  end

  assign col_o = x_tbl[item_i.x_pos];
  assign row_o = (item_i.mode == MODE_DRAW) ? y_draw : y_base;

endmodule

// ===== src/sxfb_frame_mem.sv =====
// Frame memory for the sprite XOR framebuffer: one word per screen row.
// Row valid bits give the black screen after reset and clear; a bypass
// covers a read issued in the same cycle as a write. Depends on sxfb_pkg.
`timescale 1ns / 1ps

module sxfb_frame_mem import sxfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  localparam int unsigned ROW_W = $clog2(SCREEN_HEIGHT)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sxfb_mem_cmd_t           cmd_i,
  input  logic [ROW_W-1:0]        wr_row_i,
  input  logic [SCREEN_WIDTH-1:0] wr_data_i,
  input  logic                    rd_en_i,
  input  logic [ROW_W-1:0]        rd_row_i,
  output logic [SCREEN_WIDTH-1:0] row_o
);

  logic [SCREEN_WIDTH-1:0]  mem_q [SCREEN_HEIGHT];
  logic [SCREEN_HEIGHT-1:0] row_valid_q;

  logic [SCREEN_WIDTH-1:0]  rd_data_q;
  logic                     rd_valid_q;
  logic                     byp_hit_q, byp_hit_d;
  logic [SCREEN_WIDTH-1:0]  byp_data_q, byp_data_d;

  // The read sees the old word at the write edge, so the new one is kept aside.
  assign byp_hit_d  = cmd_i.clr || (cmd_i.wr_en && (wr_row_i == rd_row_i));
  assign byp_data_d = cmd_i.clr ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_row_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q  <= mem_q[rd_row_i];
      byp_data_q <= byp_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      byp_hit_q   <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        row_valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        row_valid_q[wr_row_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= row_valid_q[rd_row_i];
        byp_hit_q  <= byp_hit_d;
      end
    end
  end

  always_comb begin
    if (byp_hit_q) begin
      row_o = byp_data_q;
    end else if (rd_valid_q) begin
      row_o = rd_data_q;
    end else begin
      row_o = '0;
    end
  end

`ifndef SYNTH
  a_clear_blanks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |=> (row_valid_q == '0))
    else $error("row valid bits not cleared after a screen clear");

  a_bypass_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en_i && cmd_i.wr_en && !cmd_i.clr && (wr_row_i == rd_row_i))
      |=> (row_o == $past(wr_data_i)))
    else $error("read of a row being written did not return the new word");

  a_write_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.wr_en && !cmd_i.clr) |=> row_valid_q[$past(wr_row_i)])
    else $error("written row not marked valid");
`endif

endmodule

// ===== src/sxfb_row_op.sv =====
// Row operation of the sprite XOR framebuffer: builds the sprite mask,
// XORs it into the row, updates collision and forms the result item.
// Depends on sxfb_pkg.
`timescale 1ns / 1ps

module sxfb_row_op import sxfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = SCREEN_WIDTH_DEF,
  localparam int unsigned COL_W = $clog2(SCREEN_WIDTH)
) (
  input  logic [1:0]              mode_i,
  input  logic [SPRITE_W-1:0]     row_bits_i,
  input  logic                    last_row_i,
  input  logic                    first_row_i,
  input  logic [COL_W-1:0]        col_i,
  input  logic [SCREEN_WIDTH-1:0] row_data_i,
  input  logic                    seen_i,
  output logic                    seen_o,
  output logic [SCREEN_WIDTH-1:0] new_row_o,
  output sxfb_mem_cmd_t           cmd_o,
  output sxfb_out_t               item_o
);

  localparam logic [COL_W:0] WidthL = (COL_W+1)'(SCREEN_WIDTH);

  logic [SCREEN_WIDTH-1:0] mask;
  logic                    coll_draw;

  // Column base is below the width and the offset below eight, so one
  // subtract wraps each pixel.
  always_comb begin
    logic [COL_W:0] xs;
    mask = '0;
    xs   = '0;
    for (int j = 0; j < SPRITE_W; j++) begin
      xs = {1'b0, col_i} + (COL_W+1)'(j);
      if (xs >= WidthL) begin
        xs = xs - WidthL;
      end
      if (row_bits_i[SPRITE_W-1-j]) begin
        mask[xs[COL_W-1:0]] = 1'b1;
      end
    end
  end

  assign coll_draw = (seen_i && !first_row_i) || (|(row_data_i & mask));
  assign new_row_o = row_data_i ^ mask;

  always_comb begin
    item_o = '0;
    cmd_o  = '0;
    seen_o = seen_i;
    unique case (mode_i)
      MODE_DRAW: begin
        item_o.collision   = coll_draw;
        item_o.sprite_done = last_row_i;
        cmd_o.wr_en        = 1'b1;
        seen_o             = coll_draw;
      end
      MODE_CLEAR: begin
        cmd_o.clr = 1'b1;
      end
      MODE_READ: begin
        item_o.pixel_value = row_data_i[col_i];
      end
      default: begin
        item_o = '0;
      end
    endcase
  end

endmodule

// ===== src/sprite_xor_framebuffer.sv =====
// A result item moves from the first stage into the result register; while
// the result register is stalled, the item waits in the first stage.
// Throughput: one item per cycle unless the result side stalls; the memory does
// one row read and write per cycle; a bypass register covers back-to-back rows.
// Reset: the screen reads black and the collision flag is clear right after
// reset; per-row valid bits blank the screen, so there is no clearing pass.
`timescale 1ns / 1ps

module sprite_xor_framebuffer import sxfb_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sxfb_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sxfb_out_t out_item_o
);

  localparam int unsigned COL_W = $clog2(SCREEN_WIDTH);
  localparam int unsigned ROW_W = $clog2(SCREEN_HEIGHT);

  // The design is two registers deep. The first stage holds an accepted item
  // with its wrapped coordinates while the frame memory returns its row. The
  // second stage is the result register. The row is modified and written back
  // as the item moves from the first stage to the result register.
  logic                    accept;
  logic                    advance;

  logic                    s1_valid_q;
  logic [1:0]              s1_mode_q;
  logic [SPRITE_W-1:0]     s1_bits_q;
  logic                    s1_last_q;
  logic                    s1_first_q;
  logic [COL_W-1:0]        s1_col_q;
  logic [ROW_W-1:0]        s1_row_q;

  logic                    out_valid_q, out_valid_d;
  sxfb_out_t               out_item_q;

  // Collision flag of the sprite being drawn.
  logic                    seen_q, seen_d;

  logic [COL_W-1:0]        in_col;
  logic [ROW_W-1:0]        in_row;
  logic [SCREEN_WIDTH-1:0] row_data;
  logic [SCREEN_WIDTH-1:0] new_row;
  sxfb_mem_cmd_t           op_cmd;
  sxfb_mem_cmd_t           mem_cmd;
  sxfb_out_t               op_item;

  // The first stage moves on when the result register is empty or drains.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  sxfb_wrap #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_wrap (
    .item_i (in_item_i),
    .col_o  (in_col),
    .row_o  (in_row)
  );

  // Memory side effects happen only when the item really leaves the stage.
  assign mem_cmd.wr_en = advance && op_cmd.wr_en;
  assign mem_cmd.clr   = advance && op_cmd.clr;

  sxfb_frame_mem #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_frame_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (mem_cmd),
    .wr_row_i  (s1_row_q),
    .wr_data_i (new_row),
    .rd_en_i   (accept),
    .rd_row_i  (in_row),
    .row_o     (row_data)
  );

  sxfb_row_op #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_row_op (
    .mode_i      (s1_mode_q),
    .row_bits_i  (s1_bits_q),
    .last_row_i  (s1_last_q),
    .first_row_i (s1_first_q),
    .col_i       (s1_col_q),
    .row_data_i  (row_data),
    .seen_i      (seen_q),
    .seen_o      (seen_d),
    .new_row_o   (new_row),
    .cmd_o       (op_cmd),
    .item_o      (op_item)
  );

  always_comb begin
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Payload registers of the first stage and of the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q  <= in_item_i.mode;
      s1_bits_q  <= in_item_i.row_bits;
      s1_last_q  <= in_item_i.last_row;
      s1_first_q <= (in_item_i.row_index == '0);
      s1_col_q   <= in_col;
      s1_row_q   <= in_row;
    end
    if (advance) begin
      out_item_q <= op_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      out_valid_q <= out_valid_d;
      if (advance) begin
        seen_q <= seen_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTH
  a_advance_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("item left the first stage but no result became valid");

  a_empty_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled while the first stage is empty");

  a_draw_no_pixel : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_item_q.collision || out_item_q.sprite_done))
      |-> !out_item_q.pixel_value)
    else $error("draw result carries a pixel value");

  a_seen_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (s1_mode_q == MODE_DRAW) && !s1_first_q && seen_q) |=> seen_q)
    else $error("collision flag dropped within a sprite");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sprite XOR framebuffer.
// Drives draw, clear, read and unused-mode items with random idling on both
// sides and checks every result against a local framebuffer model. Needs sxfb_pkg.
`timescale 1ns / 1ps

module tb_top;
  import sxfb_pkg::*;

  localparam int unsigned SCR_W = SCREEN_WIDTH_DEF;
  localparam int unsigned SCR_H = SCREEN_HEIGHT_DEF;

  // Mode code 3 is not defined by the block; it must be ignored.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // Cycles with no handshake on either side before the run is called hung.
  localparam int unsigned HANG_LIMIT = 2000;
  // Extra cycles waited after the last expected result.
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned REPORT_MAX = 10;

  // Scoreboard: keeps its own copy of the screen and the collision flag,
  // works out the result of every accepted item, and compares the results
  // that come out of the block against those expectations in order.
  class framebuffer_scoreboard;
    bit [SCR_W-1:0] frame [SCR_H];
    bit             hit_in_sprite;
    sxfb_out_t      pending [$];
    int unsigned    failures;
    int unsigned    checked;
    int unsigned    n_draw, n_read, n_clear, n_unused, n_hit, n_lit_reads;

    function void note_input(sxfb_in_t it);
      sxfb_out_t   exp_res;
      int unsigned row, col;
      exp_res = '0;
      case (it.mode)
        MODE_DRAW: begin
          n_draw++;
          row = (int'(it.y_pos) + int'(it.row_index)) % SCR_H;
          // Row zero starts a new sprite, so the flag starts over.
          if (it.row_index == 4'd0) hit_in_sprite = 1'b0;
          for (int j = 0; j < SPRITE_W; j++) begin
            if (it.row_bits[SPRITE_W-1-j]) begin
              col = (int'(it.x_pos) + j) % SCR_W;
              if (frame[row][col]) hit_in_sprite = 1'b1;
              frame[row][col] = ~frame[row][col];
            end
          end
          if (hit_in_sprite) n_hit++;
          exp_res.collision   = hit_in_sprite;
          exp_res.sprite_done = it.last_row;
        end
        MODE_CLEAR: begin
          n_clear++;
          // The collision flag survives a clear.
          for (int r = 0; r < SCR_H; r++) frame[r] = '0;
        end
        MODE_READ: begin
          n_read++;
          exp_res.pixel_value = frame[it.y_pos % SCR_H][it.x_pos % SCR_W];
          if (exp_res.pixel_value) n_lit_reads++;
        end
        default: n_unused++;
      endcase
      pending.push_back(exp_res);
    endfunction

    function void check_result(sxfb_out_t got);
      sxfb_out_t exp_res;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("error: result with nothing expected: col=%0b pix=%0b done=%0b",
                   got.collision, got.pixel_value, got.sprite_done);
        return;
      end
      exp_res = pending.pop_front();
      checked++;
      if (got.collision !== exp_res.collision || got.pixel_value !== exp_res.pixel_value ||
          got.sprite_done !== exp_res.sprite_done) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("error: result %0d expected col=%0b pix=%0b done=%0b, got col=%0b pix=%0b done=%0b",
                   checked, exp_res.collision, exp_res.pixel_value, exp_res.sprite_done,
                   got.collision, got.pixel_value, got.sprite_done);
      end
    endfunction

    function void note_leftovers();
      if (pending.size() != 0) begin
        failures += pending.size();
        $display("error: %0d expected results never arrived", pending.size());
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_stall_o;
  sxfb_in_t  in_item;
  logic      out_valid_o;
  logic      out_stall;
  sxfb_out_t out_item_o;

  framebuffer_scoreboard sb;

  int unsigned idle_cycles;
  int unsigned items_sent;
  int unsigned in_calm, in_calm_left;
  int unsigned out_calm, out_calm_left;
  logic [7:0]  last_x, last_y;

  sprite_xor_framebuffer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both handshakes are observed here at the rising edge. Inputs are noted
  // before results are checked; a result is registered after its item is
  // accepted, so no result in the same cycle can belong to the item accepted
  // in that cycle anyway. The same block runs the watchdog on cycles where
  // nothing moves.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) sb.note_input(in_item);
      if (out_valid_o && !out_stall) sb.check_result(out_item_o);
    end
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("error: no handshake for %0d cycles, %0d results outstanding",
                 HANG_LIMIT, sb.pending.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic sxfb_in_t make_item(logic [1:0] mode, logic [7:0] x, logic [7:0] y,
                                         logic [3:0] ri, logic [7:0] bits, logic last);
    sxfb_in_t it;
    it.mode      = mode;
    it.x_pos     = x;
    it.y_pos     = y;
    it.row_index = ri;
    it.row_bits  = bits;
    it.last_row  = last;
    return it;
  endfunction

  // Presents one item after a random gap and holds it until it is taken.
  // Stretches of items with no gap at all come and go at random.
  task automatic send_item(input sxfb_in_t it);
    int unsigned gap;
    if (in_calm_left == 0) begin
      in_calm      = ($urandom_range(0, 2) == 0);
      in_calm_left = $urandom_range(20, 80);
    end
    in_calm_left--;
    gap = in_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Draws a whole sprite of n rows and remembers where it went, so that
  // reads and redraws can aim at it.
  task automatic send_sprite(input logic [7:0] x, input logic [7:0] y, input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_item(make_item(MODE_DRAW, x, y, 4'(i), 8'($urandom), i == n - 1));
    last_x = x;
    last_y = y;
  endtask

  // Result side: before each result the receiver holds stall high for a
  // random number of cycles, then takes the next result that shows up.
  initial begin
    int unsigned hold;
    out_stall     = 1'b0;
    out_calm      = 0;
    out_calm_left = 0;
    @(posedge rst_ni);
    forever begin
      if (out_calm_left == 0) begin
        out_calm      = ($urandom_range(0, 2) == 0);
        out_calm_left = $urandom_range(20, 80);
      end
      out_calm_left--;
      hold = out_calm ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    int unsigned pick, nrows;
    logic [7:0]  rx, ry;
    sb           = new();
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    idle_cycles  = 0;
    items_sent   = 0;
    in_calm      = 0;
    in_calm_left = 0;
    last_x       = '0;
    last_y       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. A full row at the origin lights eight pixels with no
    // collision; reads then probe both ends of it and the pixel just past.
    send_item(make_item(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'hFF, 1'b1));
    send_item(make_item(MODE_READ, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
    send_item(make_item(MODE_READ, 8'd7, 8'd0, 4'd0, 8'h00, 1'b0));
    send_item(make_item(MODE_READ, 8'd8, 8'd0, 4'd0, 8'h00, 1'b0));
    // Erasing lit pixels raises the flag; a later row of the same sprite
    // keeps it, and a new row zero starts it over.
    send_item(make_item(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'h81, 1'b0));
    send_item(make_item(MODE_DRAW, 8'd0, 8'd0, 4'd1, 8'h00, 1'b1));
    send_item(make_item(MODE_DRAW, 8'd0, 8'd0, 4'd0, 8'h00, 1'b1));
    // Largest coordinates and row index: the row wraps on both axes.
    send_item(make_item(MODE_DRAW, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
    send_item(make_item(MODE_READ, 8'd0, 8'd14, 4'd0, 8'h00, 1'b0));
    send_item(make_item(MODE_READ, 8'd127, 8'd46, 4'hF, 8'hFF, 1'b1));
    send_item(make_item(MODE_READ, 8'd7, 8'd14, 4'd0, 8'h00, 1'b0));
    // Rightmost pixel of a row that ends exactly at the screen edge.
    send_item(make_item(MODE_DRAW, 8'd56, 8'd31, 4'd0, 8'h01, 1'b0));
    send_item(make_item(MODE_READ, 8'd63, 8'd31, 4'd0, 8'h00, 1'b0));
    // The unused mode must leave everything alone, with every field set.
    send_item(make_item(MODE_UNUSED, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
    send_item(make_item(MODE_READ, 8'd63, 8'd31, 4'd0, 8'h00, 1'b0));
    // Collision on a non-zero row, then a clear that must keep the flag.
    send_item(make_item(MODE_DRAW, 8'd56, 8'd30, 4'd1, 8'h01, 1'b0));
    send_item(make_item(MODE_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1));
    send_item(make_item(MODE_READ, 8'd0, 8'd14, 4'd0, 8'h00, 1'b0));
    send_item(make_item(MODE_DRAW, 8'd0, 8'd0, 4'd2, 8'h00, 1'b1));
    send_item(make_item(MODE_CLEAR, 8'd0, 8'd0, 4'd0, 8'h00, 1'b0));
    send_item(make_item(MODE_READ, 8'd63, 8'd31, 4'd0, 8'h00, 1'b0));

    // Random part. Most items are whole sprites, often redrawn over the
    // last one so that collisions are common, followed by reads aimed at
    // the drawn area. Clears keep the screen from filling up; unused-mode
    // items and rows with random index and end mark act as noise.
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        nrows = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 5);
        if ($urandom_range(0, 3) == 0) send_sprite(last_x, last_y, nrows);
        else send_sprite(8'($urandom), 8'($urandom), nrows);
      end else if (pick < 80) begin
        rx = last_x + 8'($urandom_range(0, 7));
        ry = last_y + 8'($urandom_range(0, 15));
        send_item(make_item(MODE_READ, rx, ry, 4'($urandom), 8'($urandom), 1'($urandom)));
      end else if (pick < 87) begin
        send_item(make_item(MODE_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom)));
      end else if (pick < 89) begin
        send_item(make_item(MODE_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom)));
      end else if (pick < 93) begin
        send_item(make_item(MODE_UNUSED, 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom)));
      end else begin
        send_item(make_item(MODE_DRAW, 8'($urandom), 8'($urandom), 4'($urandom),
                            8'($urandom), 1'($urandom)));
      end
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    // The watchdog bounds this wait if results stop coming.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    sb.note_leftovers();

    $display("Run covered %0d items: %0d draw rows (%0d with collision set), %0d reads",
             items_sent, sb.n_draw, sb.n_hit, sb.n_read);
    $display("(%0d of them lit), %0d clears, %0d unused-mode; %0d results checked, %0d failures",
             sb.n_lit_reads, sb.n_clear, sb.n_unused, sb.checked, sb.failures);
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/sxfb_pkg.sv
src/sxfb_wrap.sv
src/sxfb_frame_mem.sv
src/sxfb_row_op.sv
src/sprite_xor_framebuffer.sv
tb/tb_top.sv
